>>> hdl/c2c_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2c_pkg
// Shared types and constants of the COO to CSR merge block.
// ---------------------------------------------------------------------------
package c2c_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 512;
  localparam int unsigned DEF_MAX_DIM     = 256;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned VAL_W   = 48;
  localparam int unsigned DATA_W  = KEY_W + VAL_W;
  localparam int unsigned ROWS_W  = 9;
  localparam int unsigned PTR_W   = 10;
  localparam int unsigned PADDR_W = 3;

  localparam logic [ROWS_W-1:0] NUM_ROWS_RST = 9'd256;
  localparam logic              REG_NUM_ROWS = 1'b0;

  typedef enum logic [1:0] {
    RD_SCAN  = 2'd0,
    RD_SHIFT = 2'd1,
    RD_DRAIN = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_MERGE  = 2'd0,
    WR_SHIFT  = 2'd1,
    WR_INSERT = 2'd2
  } wr_sel_t;

  typedef struct packed {
    logic    capture;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_load_count;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    count_inc;
    logic    set_drop;
    logic    drain_step;
  } c2c_cmd_t;

  typedef struct packed {
    logic cap_kind;
    logic load_bad;
    logic idx_at_count;
    logic idx_at_pos;
    logic key_lt;
    logic key_eq;
    logic store_full;
    logic out_busy;
  } c2c_sts_t;

endpackage

>>> hdl/c2c_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2c_ram
// Generic simple dual-port RAM with registered read.
// ---------------------------------------------------------------------------
module c2c_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/c2c_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2c_dp
// Datapath: entry store, counters, row count register and result register.
// ---------------------------------------------------------------------------
module c2c_dp
  import c2c_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  c2c_cmd_t                 cmd,
  output c2c_sts_t                 sts,
  input  logic                     in_kind,
  input  logic [7:0]               in_row,
  input  logic [7:0]               in_column,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_is_entry,
  output logic [PTR_W-1:0]         out_row_pointer,
  output logic [7:0]               out_column,
  output logic signed [VAL_W-1:0]  out_value,
  output logic                     out_last,
  output logic                     out_dropped
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);
  localparam logic [31:0]   DIM_32   = 32'(DEF_MAX_DIM);

  logic              kind_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     di_r, di_nxt;
  logic [ROWS_W-1:0] pr_r, pr_nxt;
  logic              drop_r;
  logic [ROWS_W-1:0] num_rows_r;
  logic [ROWS_W-1:0] rows;

  logic              out_valid_r;
  logic              out_is_entry_r;
  logic [PTR_W-1:0]  out_ptr_r;
  logic [7:0]        out_col_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_last_r;
  logic              out_drop_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_sum;
  logic [CW-1:0]     idx_m1;
  logic [VAL_W:0]    sum_wide;
  logic [VAL_W-1:0]  sum_sat;
  logic              entry_ok;

  assign rows = ({23'd0, num_rows_r} < DIM_32) ? num_rows_r : ROWS_W'(DEF_MAX_DIM);
  assign rd_key = rd_data[DATA_W-1:VAL_W];
  assign rd_sum = rd_data[VAL_W-1:0];
  assign idx_m1 = idx_r - CW'(1);

  // saturating add of held sum and loaded value
  assign sum_wide = {rd_sum[VAL_W-1], rd_sum} + {val_r[VAL_W-1], val_r};
  always_comb begin
    if (sum_wide[VAL_W] != sum_wide[VAL_W-1]) begin
      sum_sat = {sum_wide[VAL_W], {(VAL_W-1){~sum_wide[VAL_W]}}};
    end else begin
      sum_sat = sum_wide[VAL_W-1:0];
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN:  rd_addr = idx_r[AW-1:0];
      RD_SHIFT: rd_addr = idx_m1[AW-1:0];
      RD_DRAIN: rd_addr = di_r[AW-1:0];
      default:  rd_addr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en = cmd.wr_en;
    case (cmd.wr_sel)
      WR_MERGE: begin
        wr_addr = idx_r[AW-1:0];
        wr_data = {rd_key, sum_sat};
      end
      WR_SHIFT: begin
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data;
      end
      WR_INSERT: begin
        wr_addr = pos_r[AW-1:0];
        wr_data = {key_r, val_r};
      end
      default: begin
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data;
      end
    endcase
  end

  c2c_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign entry_ok = (di_r < count_r) && ({1'b0, rd_key[15:8]} < pr_r) && (pr_r <= rows);

  always_comb begin
    sts.cap_kind     = kind_r;
    sts.load_bad     = ({1'b0, key_r[15:8]} >= rows) || ({24'd0, key_r[7:0]} >= DIM_32) ||
                       (pr_r != '0) || (di_r != '0);
    sts.idx_at_count = (idx_r == count_r);
    sts.idx_at_pos   = (idx_r == pos_r);
    sts.key_lt       = (rd_key < key_r);
    sts.key_eq       = (rd_key == key_r);
    sts.store_full   = (count_r == FULL_CNT);
    sts.out_busy     = out_valid_r && out_stall;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end else if (cmd.idx_load_count) begin
      idx_nxt = count_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    di_nxt    = di_r;
    pr_nxt    = pr_r;
    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.drain_step) begin
      if (entry_ok) begin
        di_nxt = di_r + CW'(1);
      end else if (pr_r >= rows) begin
        count_nxt = '0;
        di_nxt    = '0;
        pr_nxt    = '0;
      end else begin
        pr_nxt = pr_r + ROWS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      di_r        <= '0;
      pr_r        <= '0;
      drop_r      <= 1'b0;
      num_rows_r  <= NUM_ROWS_RST;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      pos_r       <= '0;
    end else begin
      count_r <= count_nxt;
      di_r    <= di_nxt;
      pr_r    <= pr_nxt;
      idx_r   <= idx_nxt;
      if (cmd.idx_load_count) begin
        pos_r <= idx_r;
      end
      if (cmd.set_drop) begin
        drop_r <= 1'b1;
      end
      if (psel && penable && pwrite && (paddr[2] == REG_NUM_ROWS)) begin
        num_rows_r <= pwdata[ROWS_W-1:0];
      end
      if (cmd.drain_step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      key_r  <= {in_row, in_column};
      val_r  <= in_value;
    end
    if (cmd.drain_step) begin
      out_is_entry_r <= entry_ok;
      out_ptr_r      <= entry_ok ? '0 : PTR_W'(di_r);
      out_col_r      <= entry_ok ? rd_key[7:0] : 8'd0;
      out_val_r      <= entry_ok ? rd_sum : '0;
      out_last_r     <= !entry_ok && (pr_r >= rows);
      // hold the flag as it stood for this word while the result waits
      out_drop_r     <= drop_r;
    end
  end

  assign prdata          = (paddr[2] == REG_NUM_ROWS) ? {23'd0, num_rows_r} : 32'd0;
  assign pready          = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_is_entry    = out_is_entry_r;
  assign out_row_pointer = out_ptr_r;
  assign out_column      = out_col_r;
  assign out_value       = out_val_r;
  assign out_last        = out_last_r;
  assign out_dropped     = out_drop_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above store depth");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    di_r <= count_r)
    else $error("drain index passed entry count");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_step && !entry_ok && (pr_r >= rows) |=> (count_r == '0) && out_last_r)
    else $error("final pointer did not empty the store");

endmodule

>>> hdl/c2c_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2c_ctrl
// Controller: sequences the sorted insert, merge and drain steps.
// ---------------------------------------------------------------------------
module c2c_ctrl
  import c2c_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  c2c_sts_t sts,
  output c2c_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_CMP   = 8'b0000_1000,
    ST_SHRD  = 8'b0001_0000,
    ST_SHWR  = 8'b0010_0000,
    ST_INS   = 8'b0100_0000,
    ST_DOUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.cap_kind) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_DRAIN;
          state_nxt  = ST_DOUT;
        end else if (sts.load_bad) begin
          cmd.set_drop = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.idx_at_count) begin
          if (sts.store_full) begin
            cmd.set_drop = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.idx_load_count = 1'b1;
            state_nxt          = ST_SHRD;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SCAN;
          state_nxt  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.key_eq) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_MERGE;
          state_nxt  = ST_IDLE;
        end else if (sts.key_lt) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SCAN;
        end else if (sts.store_full) begin
          cmd.set_drop = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.idx_load_count = 1'b1;
          state_nxt          = ST_SHRD;
        end
      end
      ST_SHRD: begin
        // move entries up one slot, top first, until the gap reaches the slot
        if (sts.idx_at_pos) begin
          state_nxt = ST_INS;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SHIFT;
          state_nxt  = ST_SHWR;
        end
      end
      ST_SHWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.idx_dec = 1'b1;
        state_nxt   = ST_SHRD;
      end
      ST_INS: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WR_INSERT;
        cmd.count_inc = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_DOUT: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.drain_step = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_en))
    else $error("store read and written in one cycle");

  a_one_idx_op: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.idx_clr, cmd.idx_inc, cmd.idx_dec, cmd.idx_load_count}) <= 1)
    else $error("conflicting index commands");

  a_drain_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_step |-> (state_r == ST_DOUT) && sts.cap_kind)
    else $error("drain step without a drain word");

endmodule

>>> hdl/coo_to_csr_merge_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coo_to_csr_merge_top
// Sorted, merging store of sparse entries read out in CSR order.
// ---------------------------------------------------------------------------
// One word is handled at a time; the entry store is a single-port-per-side
// RAM and each step touches it at most once per cycle. A load of a new key scans
// the held entries with a smaller key (one read and one compare each),
// moves the entries above its slot up one by one to open the slot (none
// when the new key lands at the end) and writes it in. A load that merges
// scans the same way and writes the saturated sum back in place; a load
// dropped on its row or during a drain ends after the check. A drain word
// reads one stored entry and waits while the result register is busy. No
// clearing pass follows reset. The next word is taken while a result still
// waits on out_stall, except a drain, which holds until the result is taken.
module coo_to_csr_merge_top
  import c2c_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_kind,
  input  logic [7:0]              in_row,
  input  logic [7:0]              in_column,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_is_entry,
  output logic [PTR_W-1:0]        out_row_pointer,
  output logic [7:0]              out_column,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last,
  output logic                    out_dropped,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  c2c_cmd_t cmd;
  c2c_sts_t sts;

  c2c_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  c2c_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_value        (in_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_entry    (out_is_entry),
    .out_row_pointer (out_row_pointer),
    .out_column      (out_column),
    .out_value       (out_value),
    .out_last        (out_last),
    .out_dropped     (out_dropped)
  );

endmodule

>>> dv/coo_to_csr_merge_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coo_to_csr_merge_checker
// Watches the word channels and the register port of the COO to CSR merge
// block, keeps its own sorted, merging entry store and compares every drained
// word field by field with the predicted one.
// ---------------------------------------------------------------------------
module coo_to_csr_merge_checker
  import c2c_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_kind,
  input  logic [7:0]              in_row,
  input  logic [7:0]              in_column,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_is_entry,
  input  logic [PTR_W-1:0]        out_row_pointer,
  input  logic [7:0]              out_column,
  input  logic signed [VAL_W-1:0] out_value,
  input  logic                    out_last,
  input  logic                    out_dropped,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  output int                      errors,
  output int                      pending
);

  localparam int unsigned DEPTH = DEF_MAX_ENTRIES;
  localparam int unsigned DIM   = DEF_MAX_DIM;
  localparam longint VMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VMIN = -VMAX - 1;

  typedef struct packed {
    logic                    is_entry;
    logic [PTR_W-1:0]        row_pointer;
    logic [7:0]              column;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    dropped;
  } csr_word_t;

  logic [KEY_W-1:0] held_key [DEPTH];
  longint           held_sum [DEPTH];
  int unsigned      held_count, drained, ptr_row, row_count;
  logic             drop_seen;
  csr_word_t        csr_expect_q[$];

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > VMAX) return VMAX;
    if (s < VMIN) return VMIN;
    return s;
  endfunction

  task automatic load_entry(logic [7:0] row, logic [7:0] col, longint val);
    int unsigned eff, key, pos;
    eff = (row_count < DIM) ? row_count : DIM;
    if (row >= eff || ptr_row != 0 || drained != 0) begin
      drop_seen = 1'b1;
      return;
    end
    key = row * DIM + col;
    pos = 0;
    while (pos < held_count && held_key[pos] < key) pos++;
    if (pos < held_count && held_key[pos] == key) begin
      held_sum[pos] = sat_sum(held_sum[pos], val);
      return;
    end
    if (held_count >= DEPTH) begin
      drop_seen = 1'b1;
      return;
    end
    for (int i = held_count; i > pos; i--) begin
      held_key[i] = held_key[i-1];
      held_sum[i] = held_sum[i-1];
    end
    held_key[pos] = KEY_W'(key);
    held_sum[pos] = val;
    held_count++;
  endtask

  task automatic drain_word();
    csr_word_t   w;
    int unsigned eff;
    w = '0;
    eff = (row_count < DIM) ? row_count : DIM;
    if (drained < held_count && (held_key[drained] / DIM) < ptr_row && ptr_row <= eff) begin
      w.is_entry = 1'b1;
      w.column   = 8'(held_key[drained] % DIM);
      w.value    = VAL_W'(held_sum[drained]);
      drained++;
    end else begin
      w.row_pointer = PTR_W'(drained);
      if (ptr_row >= eff) begin
        // closing pointer: empty the store
        w.last     = 1'b1;
        held_count = 0;
        drained    = 0;
        ptr_row    = 0;
      end else begin
        ptr_row++;
      end
    end
    w.dropped = drop_seen;
    csr_expect_q = {csr_expect_q, w};
  endtask

  always @(posedge clk) begin
    csr_word_t e;
    if (!rst_n) begin
      held_count = 0;
      drained    = 0;
      ptr_row    = 0;
      row_count  = NUM_ROWS_RST;
      drop_seen  = 1'b0;
      errors     = 0;
      csr_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_NUM_ROWS)
        row_count = pwdata[ROWS_W-1:0];
      if (in_valid && !in_stall) begin
        if (in_kind) drain_word();
        else load_entry(in_row, in_column, longint'(in_value));
      end
      if (out_valid && !out_stall) begin
        if (csr_expect_q.size() == 0) begin
          $error("unexpected word: is_entry=%0d ptr=%0d col=%0d value=%0d",
                 out_is_entry, out_row_pointer, out_column, out_value);
          errors++;
        end else begin
          e = csr_expect_q.pop_front();
          if (out_is_entry !== e.is_entry) begin
            $error("is_entry: expected %0d, got %0d", e.is_entry, out_is_entry);
            errors++;
          end
          if (out_row_pointer !== e.row_pointer) begin
            $error("row_pointer: expected %0d, got %0d", e.row_pointer, out_row_pointer);
            errors++;
          end
          if (out_column !== e.column) begin
            $error("column: expected %0d, got %0d", e.column, out_column);
            errors++;
          end
          if (out_value !== e.value) begin
            $error("value: expected %0d, got %0d", e.value, out_value);
            errors++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last);
            errors++;
          end
          if (out_dropped !== e.dropped) begin
            $error("dropped: expected %0d, got %0d", e.dropped, out_dropped);
            errors++;
          end
        end
      end
    end
    pending = csr_expect_q.size();
  end

endmodule

>>> dv/tb_coo_to_csr_merge_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_coo_to_csr_merge_top
// Stimulus and verdict for the COO to CSR merge block.
// ---------------------------------------------------------------------------
// Directed loads and drains cover saturation, dropped entries, loads during
// a drain and row count changes; random batches of loads followed by full
// drains run under several idle mixes.
module tb_coo_to_csr_merge_top;
  import c2c_pkg::*;

  localparam int IDLE_LIMIT = 30000;
  localparam int SETTLE     = 2200;
  localparam logic signed [VAL_W-1:0] VMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VMIN = 48'sh8000_0000_0000;

  logic                    clk, rst_n;
  logic                    in_valid, in_stall, in_kind;
  logic [7:0]              in_row, in_column;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid, out_stall, out_is_entry, out_last, out_dropped;
  logic [PTR_W-1:0]        out_row_pointer;
  logic [7:0]              out_column;
  logic signed [VAL_W-1:0] out_value;
  logic                    psel, penable, pwrite, pready;
  logic [PADDR_W-1:0]      paddr;
  logic [31:0]             pwdata, prdata;

  int   errors, pending;
  int   tx_idle, rx_idle, words_sent, idle_cycles, hold_left, words_out;
  logic hold_req;
  int   cur_rows;

  coo_to_csr_merge_top u_dut (.*);

  coo_to_csr_merge_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_row, .in_column, .in_value,
    .out_valid, .out_stall, .out_is_entry, .out_row_pointer, .out_column,
    .out_value, .out_last, .out_dropped, .psel, .penable, .pwrite, .paddr,
    .pwdata, .pready, .errors, .pending
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= 400;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      words_out <= 0;
    else if (out_valid && !out_stall)
      words_out <= words_out + 1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3: return -1;
      default: return r[VAL_W-1:0];
    endcase
  endfunction

  task automatic send(logic kind, logic [7:0] row, logic [7:0] col,
                      logic signed [VAL_W-1:0] val);
    logic taken;
    @(posedge clk);
    if ($urandom_range(99) < tx_idle) begin
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_row    <= row;
    in_column <= col;
    in_value  <= val;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    words_sent++;
    // drop valid once the word is taken
    in_valid <= 1'b0;
  endtask

  task automatic drain_all();
    logic done;
    do begin
      if ($urandom_range(9) == 0) send(1'b0, 8'($urandom), 8'($urandom), pick_value());
      send(1'b1, 8'($urandom), 8'($urandom), pick_value());
      do begin
        @(negedge clk);
        done = out_valid && !out_stall;
        @(posedge clk);
      end while (!done);
      done = out_last;
    end while (!done);
  endtask

  task automatic drain_some(int n);
    logic got;
    repeat (n) begin
      send(1'b1, 8'd0, 8'd0, '0);
      do begin
        @(negedge clk);
        got = out_valid && !out_stall;
        @(posedge clk);
      end while (!got);
    end
  endtask

  task automatic settle();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rows(int rows);
    settle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_NUM_ROWS, 2'b00});
    pwdata  <= 32'(rows);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cur_rows = rows;
  endtask

  task automatic load_batch(int n);
    logic [7:0] row, col;
    bit narrow;
    narrow = $urandom_range(1);
    repeat (n) begin
      if (cur_rows == 0 || $urandom_range(9) == 0) row = 8'($urandom);
      else row = 8'($urandom_range(cur_rows > 256 ? 255 : cur_rows - 1));
      col = narrow ? 8'($urandom_range(3)) : 8'($urandom);
      send(1'b0, row, col, pick_value());
    end
  endtask

  initial begin
    int outs_seen;
    rst_n = 1'b0; in_valid = 1'b0; in_kind = 1'b0; in_row = '0; in_column = '0;
    in_value = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0;
    pwdata = '0; hold_req = 1'b0; tx_idle = 0; rx_idle = 0; words_sent = 0;
    cur_rows = 256;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturation both ways, out-of-range row, load during drain
    write_rows(4);
    send(1'b0, 8'd2, 8'd255, VMAX);
    send(1'b0, 8'd2, 8'd255, 48'sd1);
    send(1'b0, 8'd0, 8'd0, VMIN);
    send(1'b0, 8'd0, 8'd0, -48'sd1);
    send(1'b0, 8'd3, 8'd7, 48'sh5555_5555_5555);
    send(1'b0, 8'd1, 8'd0, 48'sh2AAA_AAAA_AAAA);
    send(1'b0, 8'd255, 8'd255, -48'sd5);
    drain_some(3);
    send(1'b0, 8'd0, 8'd1, 48'sd9);
    drain_all();
    // zero rows: first drain is the closing pointer
    write_rows(0);
    drain_all();
    // rows lowered after loading
    write_rows(8);
    send(1'b0, 8'd6, 8'd1, 48'sd3);
    send(1'b0, 8'd7, 8'd2, 48'sd4);
    send(1'b0, 8'd1, 8'd2, 48'sd4);
    write_rows(2);
    drain_all();
    // rows lowered in the middle of a drain
    write_rows(8);
    send(1'b0, 8'd5, 8'd3, 48'sd7);
    drain_some(4);
    write_rows(2);
    drain_all();

    // long receiver hold-off while drains keep coming, so the input stalls
    write_rows(6);
    load_batch(5);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    outs_seen = words_out;
    repeat (3) send(1'b1, 8'd0, 8'd0, '0);
    while (words_out < outs_seen + 3) @(posedge clk);
    drain_all();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 26 : (ph == 1) ? 79 : 0;
      rx_idle = (ph == 0) ? 79 : (ph == 1) ? 26 : 0;
      while (words_sent < 25 + (ph + 1) * 160) begin
        case ($urandom_range(19))
          0: write_rows(256);
          1: write_rows(0);
          default: write_rows($urandom_range(1, 16));
        endcase
        load_batch($urandom_range(1, 24));
        drain_all();
      end
    end

    @(posedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
